// ===== rtl/core/ltyd_pkg.sv =====
// Shared types and constants for the leap-corrected time to year/day block.
// No dependencies.
`default_nettype none
package ltyd_pkg;
  localparam int TableDepth = 32;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = IdxW + 1;
  localparam logic [62:0] EpochShiftUs = 63'd378691200000000; // 4383 days
  localparam logic [36:0] UsecPerDay = 37'd86400000000;
  localparam logic [21:0] DaysTo10000 = 22'd2932897;
  localparam logic [62:0] TopUs = 63'd253402300800000000; // 1970 to 10000 in us
  localparam logic [23:0] DayOdd = 24'd10546875;           // us per day over 2^13
  localparam logic [21:0] RecipDay = 22'd3335999;          // floor(2^45 / DayOdd)

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_LOADED = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_SPLIT,
    S_DONE
  } state_t;

  // one token travelling down the cell chain
  typedef struct packed {
    logic [62:0] t;
    logic [26:0] applied;
  } tok_t;
endpackage
`default_nettype wire

// ===== rtl/core/leap_corrected_time_to_year_day.sv =====
// Top level: leap-second table chain, day divider and calendar year walk.
// Depends on ltyd_pkg, ltyd_cell, ltyd_divider.
//
//  channel   | ports                                          | handshake
//  request   | op entry_index cutoff_us offset_us time_us     | start & !busy
//  result    | status year day_of_year usec_of_day            | done (1 cycle)
//            | applied_offset_us                              |
//  config    | entry_count_data                               | entry_count_we
//
// A load goes straight to the result. A convert passes through the cell
// chain (one cell per slot), then the day divider, and then the year walk steps
// one calendar year at a time past 1970 (up to about 8030 years).
// Synchronous active-high reset clears control and entry_count; table
// contents stay undefined until loaded. Results cannot be stalled.
`default_nettype none
module leap_corrected_time_to_year_day import ltyd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        entry_count_we,
  input  wire logic [5:0]  entry_count_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        op,
  input  wire logic [4:0]  entry_index,
  input  wire logic [62:0] cutoff_us,
  input  wire logic [26:0] offset_us,
  input  wire logic [62:0] time_us,
  output logic             done,
  output logic [1:0]       status,
  output logic [13:0]      year,
  output logic [8:0]       day_of_year,
  output logic [36:0]      usec_of_day,
  output logic [26:0]      applied_offset_us
);
  state_t state, state_next;
  logic [5:0] entry_count;
  logic [CntW-1:0] n_used;
  logic [IdxW:0] scan_cnt;
  tok_t chain [TableDepth+1];
  logic [62:0] rem_t;
  logic [26:0] applied;
  logic        div_go, div_done;
  logic [62:0] quo;
  logic [36:0] rem;
  logic [21:0] days;
  logic [13:0] yr;
  logic [6:0]  y100;
  logic [1:0]  cen4;
  logic [8:0]  ylen;
  logic        leap;
  logic        accept;

  assign accept = start && state == S_IDLE;
  assign busy = state != S_IDLE;
  assign n_used = (entry_count > 6'(TableDepth)) ? CntW'(TableDepth) : CntW'(entry_count);

  always_ff @(posedge clk) begin
    if (rst) entry_count <= '0;
    else if (entry_count_we) entry_count <= entry_count_data;
  end

  // feed the chain straight from the time_us input
  assign chain[0].t = time_us;
  assign chain[0].applied = '0;

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    ltyd_cell u_cell (
      .clk(clk),
      .wr(accept && !op && entry_index == IdxW'(g)),
      .wr_cut(cutoff_us),
      .wr_off(offset_us),
      .active(CntW'(g) < n_used),
      .tok_in(chain[g]),
      .tok_out(chain[g+1])
    );
  end

  // leap test on the walking year: year mod 100 and century mod 4 walk beside it
  assign leap = (yr[1:0] == 2'd0 && y100 != 7'd0) || (y100 == 7'd0 && cen4 == 2'd0);
  assign ylen = leap ? 9'd366 : 9'd365;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = op ? S_SCAN : S_DONE;
      S_SCAN:  if (scan_cnt == (IdxW+1)'(TableDepth - 1)) state_next = S_DIV;
      S_DIV:   if (div_done) state_next = S_SPLIT;
      S_SPLIT: if (days < 22'(ylen) || status == ST_RANGE) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    done = state == S_DONE;
    year = yr;
    day_of_year = days[8:0] + 9'd1;
    usec_of_day = rem;
    applied_offset_us = applied;
    if (status != ST_OK) begin
      year = '0;
      day_of_year = '0;
      usec_of_day = '0;
    end
    if (status == ST_LOADED) applied_offset_us = '0;
  end

  ltyd_divider u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(rem_t),
    .done(div_done), .quo(quo), .rem(rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      div_go <= 1'b0;
    end else begin
      state <= state_next;
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          scan_cnt <= '0;
          status <= op ? ST_OK : ST_LOADED;
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + (IdxW+1)'(1);
          if (scan_cnt == (IdxW+1)'(TableDepth - 1)) begin
            // drop the epoch shift and the leap offset
            applied <= chain[TableDepth].applied;
            rem_t <= chain[TableDepth].t - EpochShiftUs - 63'(chain[TableDepth].applied);
            if (chain[TableDepth].t < EpochShiftUs + 63'(chain[TableDepth].applied))
              status <= ST_RANGE;
            div_go <= 1'b1;
          end
        end
        S_DIV: if (div_done) begin
          yr <= 14'd1970;
          y100 <= 7'd70;
          cen4 <= 2'd3;
          days <= quo[21:0];
          if (quo >= 63'(DaysTo10000)) status <= ST_RANGE;
        end
        S_SPLIT: if (days >= 22'(ylen) && status != ST_RANGE) begin
          days <= days - 22'(ylen);
          yr <= yr + 14'd1;
          if (y100 == 7'd99) begin
            y100 <= '0;
            cen4 <= cen4 + 2'd1;
          end else begin
            y100 <= y100 + 7'd1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/ltyd_cell.sv =====
// One table slot: holds cutoff and offset, updates the passing token.
// Depends on ltyd_pkg.
`default_nettype none
module ltyd_cell import ltyd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        wr,
  input  wire logic [62:0] wr_cut,
  input  wire logic [26:0] wr_off,
  input  wire logic        active,
  input  tok_t             tok_in,
  output tok_t             tok_out
);
  logic [62:0] cut;
  logic [26:0] off;

  always_ff @(posedge clk) begin
    if (wr) begin
      cut <= wr_cut;
      off <= wr_off;
    end
    tok_out.t <= tok_in.t;
    // later in-use entry with cutoff not later wins
    tok_out.applied <= (active && cut <= tok_in.t) ? off : tok_in.applied;
  end
endmodule
`default_nettype wire

// ===== rtl/core/ltyd_divider.sv =====
// Day divider: splits a microsecond count into whole days and microsecond of day
// by reciprocal multiplication and two correction steps. Depends on ltyd_pkg.
`default_nettype none
module ltyd_divider import ltyd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [62:0] num,
  output logic             done,
  output logic [62:0] quo,
  output logic [36:0] rem
);
  logic [2:0]  step;
  logic        over;
  logic [62:0] num_q;
  logic [21:0] q_est;
  logic [53:0] est;
  logic [45:0] back_odd;
  logic [58:0] back;
  logic [58:0] diff;
  logic [38:0] part;

  // a day is 2^13 * DayOdd; estimate from the top 32 bits, never above the quotient
  assign est = num_q[57:26] * RecipDay;
  assign back_odd = q_est * DayOdd;
  assign diff = num_q[58:0] - back;
  // saturate at the year 10000 boundary so the caller flags the range
  assign quo = over ? 63'(DaysTo10000) : {41'd0, q_est};
  assign rem = part[36:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        num_q <= num;
        over <= num >= TopUs;
        step <= 3'd1;
      end else begin
        case (step)
          3'd1: begin
            q_est <= est[53:32];
            step <= 3'd2;
          end
          3'd2: begin
            back <= {back_odd, 13'd0};
            step <= 3'd3;
          end
          3'd3: begin
            part <= diff[38:0];
            step <= 3'd4;
          end
          3'd4, 3'd5: begin
            // the estimate is at most two days short
            if (part >= {2'd0, UsecPerDay}) begin
              part <= part - {2'd0, UsecPerDay};
              q_est <= q_est + 22'd1;
            end
            step <= (step == 3'd5) ? 3'd0 : step + 3'd1;
            done <= step == 3'd5;
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== dv/leap_corrected_time_to_year_day_tb.sv =====
// Self-checking testbench for leap_corrected_time_to_year_day: loads leap tables,
// converts times and checks each result against its own calendar arithmetic.
// Depends on ltyd_pkg and the RTL of the block.
`default_nettype none

class year_day_board;
  typedef struct {
    ltyd_pkg::status_t status;
    logic [13:0] year;
    logic [8:0]  doy;
    logic [36:0] usec;
    logic [26:0] offset;
  } day_result_t;

  longint unsigned cutoffs[32];
  longint unsigned offsets[32];
  int unsigned     count;
  day_result_t     awaited[$];
  int unsigned     mismatches;

  function void set_count(int unsigned v);
    count = v;
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  // Turn days since 1970 into year and day of year (civil calendar via March years).
  function void civil_date(longint unsigned days, output longint unsigned yr,
                           output longint unsigned dy);
    longint unsigned z, era, doe, yoe, y, dm, mp;
    bit leap;
    z = days + 719468;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    y = yoe + era * 400;
    dm = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * dm + 2) / 153;
    if (mp < 10) begin
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      yr = y;
      dy = dm + 60 + (leap ? 1 : 0);
    end else begin
      yr = y + 1;
      dy = dm - 305;
    end
  endfunction

  function void note_request(bit op, int unsigned idx, longint unsigned cut,
                             longint unsigned off, longint unsigned t);
    day_result_t e;
    int unsigned lim;
    longint unsigned applied, r, days, yr, dy, shift;
    e = '{ltyd_pkg::ST_LOADED, '0, '0, '0, '0};
    if (op == 1'b0) begin
      cutoffs[idx] = cut;
      offsets[idx] = off;
    end else begin
      lim = (count < 32) ? count : 32;
      applied = 0;
      for (int i = 0; i < lim; i++)
        if (cutoffs[i] <= t) applied = offsets[i];
      shift = 64'(ltyd_pkg::EpochShiftUs);
      e.status = ltyd_pkg::ST_RANGE;
      e.offset = applied[26:0];
      if (t >= shift + applied) begin
        r = t - shift - applied;
        days = r / 64'(ltyd_pkg::UsecPerDay);
        if (days < 64'(ltyd_pkg::DaysTo10000)) begin
          civil_date(days, yr, dy);
          e.status = ltyd_pkg::ST_OK;
          e.year = yr[13:0];
          e.doy = dy[8:0];
          e.usec = 37'(r % 64'(ltyd_pkg::UsecPerDay));
        end
      end
    end
    awaited.push_back(e);
  endfunction

  function void check_result(logic [1:0] st, logic [13:0] yr, logic [8:0] dy,
                             logic [36:0] us, logic [26:0] off);
    day_result_t e;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: status %0d year %0d", st, yr);
      return;
    end
    e = awaited.pop_front();
    if (st !== e.status || yr !== e.year || dy !== e.doy || us !== e.usec
        || off !== e.offset) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp st %0d y %0d d %0d us %0d off %0d, got st %0d y %0d d %0d us %0d off %0d",
                 e.status, e.year, e.doy, e.usec, e.offset, st, yr, dy, us, off);
    end
  endfunction
endclass

module leap_corrected_time_to_year_day_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ltyd_pkg::*;

  localparam bit OP_LOAD = 1'b0;
  localparam bit OP_CONVERT = 1'b1;
  localparam longint unsigned MASK63 = 64'h7fff_ffff_ffff_ffff;
  localparam longint unsigned DAY_US = 64'(UsecPerDay);
  localparam longint unsigned EPOCH = 64'(EpochShiftUs);
  localparam longint unsigned TOP_US = EPOCH + 64'(DaysTo10000) * DAY_US;
  // worst case: every request walks to year 9999 and idles between requests
  localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        entry_count_we = 1'b0;
  logic [5:0]  entry_count_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic        op = 1'b0;
  logic [4:0]  entry_index = '0;
  logic [62:0] cutoff_us = '0;
  logic [26:0] offset_us = '0;
  logic [62:0] time_us = '0;
  logic        done;
  logic [1:0]  status;
  logic [13:0] year;
  logic [8:0]  day_of_year;
  logic [36:0] usec_of_day;
  logic [26:0] applied_offset_us;

  year_day_board board = new();
  bit            steady = 1'b0;   // no idle gaps while set
  longint unsigned cycles = 0;

  leap_corrected_time_to_year_day DUT (
    .clk(clk), .rst(rst),
    .entry_count_we(entry_count_we), .entry_count_data(entry_count_data),
    .start(start), .busy(busy),
    .op(op), .entry_index(entry_index), .cutoff_us(cutoff_us),
    .offset_us(offset_us), .time_us(time_us),
    .done(done), .status(status), .year(year), .day_of_year(day_of_year),
    .usec_of_day(usec_of_day), .applied_offset_us(applied_offset_us)
  );

  always #6 clk = ~clk;

  // Abandon the run once it exceeds the cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("leap_corrected_time_to_year_day_tb NOT OK");
      $finish;
    end
  end

  // Results cannot be held off: check every strobed one as it passes.
  always @(posedge clk) begin
    if (!rst && done)
      board.check_result(status, year, day_of_year, usec_of_day, applied_offset_us);
  end

  function automatic longint unsigned rnd63();
    return {$urandom, $urandom} & MASK63;
  endfunction

  // Realistic table entry: one leap step every year from 1972, ten seconds upwards.
  function automatic longint unsigned std_cutoff(int unsigned k);
    return EPOCH + (730 + 365 * longint'(k)) * DAY_US;
  endfunction

  function automatic longint unsigned std_offset(int unsigned k);
    return (k == 31) ? 64'd100_000_000 : (10 + longint'(k)) * 64'd1_000_000;
  endfunction

  // Present one request; hold start high until the block takes it.
  task automatic issue(bit o, int unsigned idx, longint unsigned cut,
                       longint unsigned off, longint unsigned t);
    if (!steady && $urandom_range(0, 99) < 23) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    entry_index <= idx[4:0];
    cutoff_us <= cut[62:0];
    offset_us <= off[26:0];
    time_us <= t[62:0];
    do @(posedge clk); while (busy);
    board.note_request(o, idx, cut, off, t);
  endtask

  // Write the entry count once everything in flight has come back.
  task automatic write_count(int unsigned v);
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    entry_count_we <= 1'b1;
    entry_count_data <= v[5:0];
    @(posedge clk);
    entry_count_we <= 1'b0;
    board.set_count(v);
  endtask

  task automatic convert(longint unsigned t);
    issue(OP_CONVERT, $urandom_range(0, 31), rnd63(), $urandom_range(0, 100_000_000), t);
  endtask

  // One random request: mostly conversions shaped around the table, a few reloads.
  task automatic random_request();
    int unsigned pick, k, lim;
    longint unsigned t;
    lim = (board.count < 32) ? board.count : 32;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, 31);
    if (pick < 8) begin
      if ($urandom_range(0, 9) < 6)
        issue(OP_LOAD, k, std_cutoff(k) + $urandom_range(0, 1000), std_offset(k), rnd63());
      else
        issue(OP_LOAD, k, ($urandom_range(0, 1) ? rnd63() : EPOCH + rnd63() % (60 * 365 * DAY_US)),
              $urandom_range(0, 100_000_000), rnd63());
      return;
    end
    if (pick < 38 && lim > 0)
      t = board.cutoffs[$urandom_range(0, lim - 1)] + $urandom_range(0, 6_000_000) - 3_000_000;
    else if (pick < 76)
      t = EPOCH + rnd63() % (130 * 365 * DAY_US) + $urandom_range(0, 100_000_000);
    else if (pick < 84)
      t = EPOCH + $urandom_range(0, 200_000_000) - 100_000_000;
    else if (pick < 87)
      t = EPOCH + rnd63() % (64'(DaysTo10000) * DAY_US);
    else if (pick < 89)
      t = TOP_US + $urandom_range(0, 200_000_000) - 100_000_000;
    else
      t = rnd63();
    convert(t & MASK63);
  endtask

  initial begin
    int unsigned counts[7];
    counts = '{32, 1, 0, 33, 63, 5, 20};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table: no offset applies; probe both ends of the calendar range.
    write_count(0);
    convert(0);
    convert(MASK63);
    convert(EPOCH - 1);
    convert(EPOCH);
    convert(EPOCH + DAY_US - 1);
    convert(EPOCH + 11016 * DAY_US);      // 2000-02-29
    convert(EPOCH + 11322 * DAY_US);      // 2000-12-31, day 366
    convert(TOP_US - 1);                  // last microsecond of 9999
    convert(TOP_US);

    // Extreme loads, then the realistic table over every slot.
    issue(OP_LOAD, 0, MASK63, 100_000_000, 0);
    issue(OP_LOAD, 31, 0, 0, MASK63);
    for (int k = 0; k < 32; k++) begin
      issue(OP_LOAD, k, std_cutoff(k), std_offset(k), rnd63());
    end

    // Phases over several entry counts, extremes included.
    foreach (counts[p]) begin
      write_count(counts[p]);
      steady = (p == 2);
      if (p == 0) begin
        convert(std_cutoff(0) - 1);
        convert(std_cutoff(0));
        convert(std_cutoff(31));
        convert(EPOCH + 100_000_000 - 1);
      end
      repeat (155) random_request();
    end
    steady = 1'b0;

    // Unsorted table: a late small cutoff must win over earlier ones.
    issue(OP_LOAD, 3, EPOCH, 42_000_000, 0);
    write_count(32);
    repeat (20) random_request();

    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.mismatches == 0)
      $display("leap_corrected_time_to_year_day_tb OK");
    else
      $display("leap_corrected_time_to_year_day_tb NOT OK");
    $finish;
  end
endmodule

`default_nettype wire
